@@ rtl/core/nma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbourhood median accumulator package
// Shared types, constants and the window size function.
// ----------------------------------------------------------------------------
package nma_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned StoreDepth = 128;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PosW       = AddrW + 2;
  localparam int unsigned CntW       = 7;
  localparam int unsigned LimW       = CntW + 1;
  localparam int unsigned RadW       = 2;
  localparam logic [RadW-1:0] MaxRadius = 2'd2;

  localparam logic [1:0] RegRadius0 = 2'd0;
  localparam logic [1:0] RegRadius1 = 2'd1;
  localparam logic [1:0] RegRadius2 = 2'd2;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef enum logic [3:0] {
    StIdle,
    StFirst,
    StMedRd,
    StMed,
    StScanRd,
    StScan,
    StShiftRd,
    StShift,
    StFin,
    StOutRd,
    StOut
  } nma_state_e;

  typedef struct packed {
    logic accept;
    logic first;
    logic decide;
    logic scan_step;
    logic shift;
    logic finish;
    logic load_out;
  } nma_cmd_t;

  typedef struct packed {
    logic upper_zero_next;
    logic scan_go;
    logic shift_more;
    logic last;
    logic out_free;
  } nma_status_t;

  function automatic logic [CntW-1:0] win_total(input logic [RadW-1:0] r0,
                                                input logic [RadW-1:0] r1,
                                                input logic [RadW-1:0] r2);
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
    logic [8:0] p;
    a = {(r0 > MaxRadius) ? MaxRadius : r0, 1'b1};
    b = {(r1 > MaxRadius) ? MaxRadius : r1, 1'b1};
    c = {(r2 > MaxRadius) ? MaxRadius : r2, 1'b1};
    p = {6'd0, a} * {6'd0, b} * {6'd0, c};
    return p[CntW-1:0];
  endfunction

endpackage

@@ rtl/core/nma_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbourhood median accumulator controller
// Sequences the first write, the median read, the outward scan, the shifting insertion and the median hand-over.
// ----------------------------------------------------------------------------
module nma_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nma_pkg::nma_status_t st_i,
  output nma_pkg::nma_cmd_t    cmd_o
);

  nma_pkg::nma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nma_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nma_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = st_i.upper_zero_next ? nma_pkg::StFirst : nma_pkg::StMedRd;
        end
      end
      nma_pkg::StFirst:   state_d = nma_pkg::StFin;
      nma_pkg::StMedRd:   state_d = nma_pkg::StMed;
      nma_pkg::StMed:     state_d = nma_pkg::StScanRd;
      nma_pkg::StScanRd:  state_d = nma_pkg::StScan;
      nma_pkg::StScan: begin
        if (st_i.scan_go) begin
          state_d = nma_pkg::StScanRd;
        end else begin
          state_d = st_i.shift_more ? nma_pkg::StShiftRd : nma_pkg::StFin;
        end
      end
      nma_pkg::StShiftRd: state_d = nma_pkg::StShift;
      nma_pkg::StShift:   state_d = st_i.shift_more ? nma_pkg::StShiftRd : nma_pkg::StFin;
      nma_pkg::StFin:     state_d = st_i.last ? nma_pkg::StOutRd : nma_pkg::StIdle;
      nma_pkg::StOutRd:   state_d = nma_pkg::StOut;
      nma_pkg::StOut: begin
        if (st_i.out_free) begin
          state_d = nma_pkg::StIdle;
        end
      end
      default: state_d = nma_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      nma_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      nma_pkg::StFirst: cmd_o.first  = 1'b1;
      nma_pkg::StMed:   cmd_o.decide = 1'b1;
      nma_pkg::StScan: begin
        cmd_o.scan_step = st_i.scan_go;
        cmd_o.shift     = !st_i.scan_go;
      end
      nma_pkg::StShift: cmd_o.shift    = 1'b1;
      nma_pkg::StFin:   cmd_o.finish   = 1'b1;
      nma_pkg::StOut:   cmd_o.load_out = st_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/nma_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbourhood median accumulator datapath
// Holds the sorted store, the radius registers, the window bookkeeping and the output register.
// ----------------------------------------------------------------------------
module nma_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [nma_pkg::RadW-1:0]         cfg_data_i,
  input  nma_pkg::sample_t                 sample_i,
  input  logic                             window_start_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nma_pkg::sample_t                 median_o,
  input  nma_pkg::nma_cmd_t                cmd_i,
  output nma_pkg::nma_status_t             st_o
);

  localparam int unsigned CntW = nma_pkg::CntW;
  localparam int unsigned LimW = nma_pkg::LimW;
  localparam int unsigned PosW = nma_pkg::PosW;
  localparam int unsigned AddrW = nma_pkg::AddrW;

  nma_pkg::sample_t mem [nma_pkg::StoreDepth];
  nma_pkg::sample_t rdata_q;
  logic             rd_ok_q;

  logic [nma_pkg::RadW-1:0] r0_q, r1_q, r2_q, r0_d, r1_d, r2_d;
  logic [CntW-1:0]          total_q, total_d, total_n;
  logic [CntW-1:0]          uc_q, uc_d, lc_q, lc_d, samples_q, samples_d;
  logic signed [LimW-1:0]   ul_q, ul_d, ll_q, ll_d, lim_q, lim_d, idx_q, idx_d;
  logic signed [PosW-1:0]   pos_q, pos_d, med_q, med_d;
  nma_pkg::sample_t         v_q, v_d, out_q, out_d;
  logic                     up_q, up_d, out_valid_q, out_valid_d;

  logic [CntW-1:0]          uc_a, lc_a;
  logic signed [LimW-1:0]   ul_a, ll_a, uce, lce;
  logic signed [PosW-1:0]   med_a, phys, pos_step;
  logic                     pos_ok, up_a, mem_we;
  nma_pkg::sample_t         rv;

  assign phys     = pos_q + PosW'(1);
  assign pos_ok   = (phys[PosW-1:AddrW] == '0);
  assign rv       = rd_ok_q ? rdata_q : '0;
  assign pos_step = up_q ? (pos_q + PosW'(1)) : (pos_q - PosW'(1));
  assign mem_we   = (cmd_i.first || cmd_i.shift) && pos_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[phys[AddrW-1:0]] <= v_q;
    end
    rdata_q <= mem[phys[AddrW-1:0]];
  end

  assign st_o.upper_zero_next = window_start_i || (uc_q == '0);
  assign st_o.scan_go    = (idx_q < lim_q) && (up_q ? (v_q >= rv) : (v_q <= rv));
  assign st_o.shift_more = (idx_q + LimW'(1)) <= lim_q;
  assign st_o.last       = ({1'b0, samples_q} + (CntW + 1)'(1)) >= {1'b0, total_q};
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  // Balance step and scan limit for the side chosen against the current median.
  always_comb begin
    up_a  = v_q >= rv;
    uc_a  = uc_q;
    lc_a  = lc_q;
    ul_a  = ul_q;
    ll_a  = ll_q;
    med_a = med_q;
    if (up_a && (uc_q > lc_q)) begin
      med_a = med_q + PosW'(1);
      uc_a  = uc_q - CntW'(1);
      lc_a  = lc_q + CntW'(1);
      ul_a  = ul_q - LimW'(1);
      ll_a  = ll_q + LimW'(1);
    end else if (!up_a && (lc_q > uc_q)) begin
      med_a = med_q - PosW'(1);
      lc_a  = lc_q - CntW'(1);
      uc_a  = uc_q + CntW'(1);
      ll_a  = ll_q - LimW'(1);
      ul_a  = ul_q + LimW'(1);
    end
    uce = $signed({1'b0, uc_a});
    lce = $signed({1'b0, lc_a});
  end

  always_comb begin
    r0_d = r0_q;
    r1_d = r1_q;
    r2_d = r2_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nma_pkg::RegRadius0: r0_d = cfg_data_i;
        nma_pkg::RegRadius1: r1_d = cfg_data_i;
        nma_pkg::RegRadius2: r2_d = cfg_data_i;
        default: begin
        end
      endcase
    end
    total_n = nma_pkg::win_total(r0_d, r1_d, r2_d);
  end

  always_comb begin
    total_d     = total_q;
    uc_d        = uc_q;
    lc_d        = lc_q;
    ul_d        = ul_q;
    ll_d        = ll_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    med_d       = med_q;
    samples_d   = samples_q;
    v_d         = v_q;
    up_d        = up_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.accept) begin
      v_d = sample_i;
      if (window_start_i) begin
        uc_d      = '0;
        lc_d      = '0;
        samples_d = '0;
        med_d     = $signed({2'b00, total_q >> 1});
        pos_d     = $signed({2'b00, total_q >> 1});
      end else begin
        pos_d = med_q;
      end
    end

    if (cmd_i.first) begin
      uc_d = CntW'(1);
      lc_d = CntW'(1);
      ul_d = $signed({1'b0, CntW'(({1'b0, total_q} + (CntW + 1)'(1)) >> 1)});
      ll_d = $signed({1'b0, CntW'(({1'b0, total_q} + (CntW + 1)'(1)) >> 1)});
    end

    if (cmd_i.decide) begin
      up_d  = up_a;
      uc_d  = uc_a;
      lc_d  = lc_a;
      ul_d  = ul_a;
      ll_d  = ll_a;
      med_d = med_a;
      pos_d = med_a;
      idx_d = '0;
      if (up_a) begin
        lim_d = (uce < ul_a) ? uce : ul_a;
      end else begin
        lim_d = (lce < ll_a) ? lce : ll_a;
      end
    end

    if (cmd_i.scan_step) begin
      pos_d = pos_step;
      idx_d = idx_q + LimW'(1);
    end

    if (cmd_i.shift) begin
      v_d   = rv;
      pos_d = pos_step;
      idx_d = idx_q + LimW'(1);
      if (!st_o.shift_more) begin
        if (up_q) begin
          uc_d = uc_q + CntW'(1);
          ll_d = ll_q - LimW'(1);
        end else begin
          lc_d = lc_q + CntW'(1);
          ul_d = ul_q - LimW'(1);
        end
      end
    end

    if (cmd_i.finish) begin
      samples_d = samples_q + CntW'(1);
      pos_d     = med_q;
    end

    if (cmd_i.load_out) begin
      out_d       = rv;
      out_valid_d = 1'b1;
      uc_d        = '0;
      lc_d        = '0;
      samples_d   = '0;
      med_d       = $signed({2'b00, total_q >> 1});
    end

    if (cfg_we_i && (cfg_idx_i <= nma_pkg::RegRadius2)) begin
      total_d   = total_n;
      uc_d      = '0;
      lc_d      = '0;
      samples_d = '0;
      med_d     = $signed({2'b00, total_n >> 1});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q        <= 2'd1;
      r1_q        <= 2'd1;
      r2_q        <= 2'd0;
      total_q     <= CntW'(9);
      med_q       <= PosW'(4);
      uc_q        <= '0;
      lc_q        <= '0;
      ul_q        <= '0;
      ll_q        <= '0;
      samples_q   <= '0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      up_q        <= 1'b0;
      idx_q       <= '0;
      lim_q       <= '0;
      pos_q       <= '0;
    end else begin
      r0_q        <= r0_d;
      r1_q        <= r1_d;
      r2_q        <= r2_d;
      total_q     <= total_d;
      med_q       <= med_d;
      uc_q        <= uc_d;
      lc_q        <= lc_d;
      ul_q        <= ul_d;
      ll_q        <= ll_d;
      samples_q   <= samples_d;
      out_valid_q <= out_valid_d;
      rd_ok_q     <= pos_ok;
      up_q        <= up_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = out_q;

  a_first_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.first |-> pos_ok)
    else $error("first sample of a window addressed outside the store");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a beat");

  a_upper_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc_q <= total_q)
    else $error("upper fill count exceeds window size");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !cfg_we_i |=> (samples_q == '0) && (uc_q == '0))
    else $error("window not cleared after emitting a median");

endmodule

@@ rtl/core/neighborhood_median_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbourhood median accumulator
// Streams the samples of one neighbourhood and emits their exact median.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  sample_i, window_start_i
// out      output     out_valid_o / out_ready_i median_o
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// The first sample of a window runs the first-write and finish states; any other
// runs the median read and decision, the scan steps, the shift steps and finish.
// The single port of the sorted store, with its registered read, sets the pace.
// The last sample of a window adds the median read and hand-over.
// Reset restores radii 1, 1 and 0; the store itself is not cleared.
// A stalled output holds the controller until the median beat can be loaded.
// ----------------------------------------------------------------------------
module neighborhood_median_accumulator_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [nma_pkg::RadW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       sample_i,
  input  logic                     window_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       median_o
);

  nma_pkg::nma_cmd_t    cmd;
  nma_pkg::nma_status_t st;

  nma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  nma_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .window_start_i (window_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_o       (median_o),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbourhood median accumulator testbench
// Streams neighbourhood samples through the block under several radius
// settings and checks every median beat against an insertion-sort predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 400;

  class median_scoreboard;
    logic [nma_pkg::RadW-1:0] radius [3];
    nma_pkg::sample_t         store [nma_pkg::StoreDepth];
    int                       med_pos;
    int                       taken;
    int                       up_cnt;
    int                       lo_cnt;
    int                       up_lim;
    int                       lo_lim;
    int                       total;
    nma_pkg::sample_t         medians [$];

    function new();
      foreach (store[i]) store[i] = '0;
      radius[0] = 2'd1;
      radius[1] = 2'd1;
      radius[2] = 2'd0;
      retotal();
      clear_win();
      up_lim = 0;
      lo_lim = 0;
    endfunction

    function int eff(logic [nma_pkg::RadW-1:0] r);
      return (r > nma_pkg::MaxRadius) ? int'(nma_pkg::MaxRadius) : int'(r);
    endfunction

    function void retotal();
      total = (2 * eff(radius[0]) + 1) * (2 * eff(radius[1]) + 1) *
              (2 * eff(radius[2]) + 1);
    endfunction

    function void clear_win();
      up_cnt = 0;
      lo_cnt = 0;
      taken = 0;
      med_pos = total / 2;
    endfunction

    function void set_radius(int idx, logic [nma_pkg::RadW-1:0] v);
      radius[idx] = v;
      retotal();
      clear_win();
    endfunction

    function nma_pkg::sample_t rd(int p);
      if (p + 1 < 0 || p + 1 >= nma_pkg::StoreDepth) return '0;
      return store[p + 1];
    endfunction

    function void wr(int p, nma_pkg::sample_t v);
      if (p + 1 < 0 || p + 1 >= nma_pkg::StoreDepth) return;
      store[p + 1] = v;
    endfunction

    function void insert(nma_pkg::sample_t v);
      int               lim;
      int               p;
      int               k;
      nma_pkg::sample_t t;
      if (up_cnt == 0) begin
        wr(med_pos, v);
        up_cnt = 1;
        lo_cnt = 1;
        up_lim = (total + 1) / 2;
        lo_lim = up_lim;
        return;
      end
      if (v >= rd(med_pos)) begin
        if (up_cnt > lo_cnt) begin
          med_pos++; up_cnt--; lo_cnt++; up_lim--; lo_lim++;
        end
        lim = (up_cnt < up_lim) ? up_cnt : up_lim;
        p = med_pos;
        k = 0;
        while (k < lim && v >= rd(p)) begin
          p++; k++;
        end
        while (k <= lim) begin
          t = rd(p); wr(p, v); v = t; p++; k++;
        end
        up_cnt++;
        lo_lim--;
      end else begin
        if (lo_cnt > up_cnt) begin
          med_pos--; lo_cnt--; up_cnt++; lo_lim--; up_lim++;
        end
        lim = (lo_cnt < lo_lim) ? lo_cnt : lo_lim;
        p = med_pos;
        k = 0;
        while (k < lim && v <= rd(p)) begin
          p--; k++;
        end
        while (k <= lim) begin
          t = rd(p); wr(p, v); v = t; p--; k++;
        end
        lo_cnt++;
        up_lim--;
      end
    endfunction

    function void note_beat(nma_pkg::sample_t s, logic start);
      if (start) clear_win();
      insert(s);
      taken++;
      if (taken >= total) begin
        medians.push_back(rd(med_pos));
        clear_win();
      end
    endfunction

    // 0: match, 1: no median waiting, 2: wrong value.
    function int check(nma_pkg::sample_t got, output nma_pkg::sample_t want);
      want = '0;
      if (medians.size() == 0) return 1;
      want = medians.pop_front();
      return (got === want) ? 0 : 2;
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [nma_pkg::RadW-1:0] cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  nma_pkg::sample_t         sample_i;
  logic                     window_start_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  nma_pkg::sample_t         median_o;

  median_scoreboard sb;
  int               errors;
  int               cycles;
  int               burst_left;
  int               stall_mode;
  int               win_pos;

  neighborhood_median_accumulator_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what, nma_pkg::sample_t got, nma_pkg::sample_t want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output stall pattern: runs of free flow, random stalls and long stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    nma_pkg::sample_t want;
    int               res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res = sb.check(median_o, want);
      if (res == 1) report("unexpected median beat", median_o, want);
      else if (res == 2) report("median", median_o, want);
    end
  end

  task automatic send(nma_pkg::sample_t s, logic start);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    window_start_i <= start;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_beat(s, start);
    @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.medians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [1:0] idx, logic [nma_pkg::RadW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_radius(int'(idx), v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_radii(logic [nma_pkg::RadW-1:0] a, logic [nma_pkg::RadW-1:0] b,
                           logic [nma_pkg::RadW-1:0] c);
    drain();
    write_radius(nma_pkg::RegRadius0, a);
    write_radius(nma_pkg::RegRadius1, b);
    write_radius(nma_pkg::RegRadius2, c);
    win_pos = 0;
  endtask

  function automatic nma_pkg::sample_t pick_sample();
    case ($urandom_range(0, 3))
      0: return nma_pkg::sample_t'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return nma_pkg::sample_t'($signed($urandom_range(0, 15)) - 8);
    endcase
  endfunction

  task automatic run_windows(int n);
    logic start;
    repeat (n) begin
      if (win_pos == 0) start = 1'($urandom_range(0, 1));
      else start = ($urandom_range(0, 149) == 0);
      if (start) win_pos = 0;
      send(pick_sample(), start);
      win_pos++;
      if (win_pos >= sb.total) win_pos = 0;
    end
  endtask

  initial begin
    sb = new();
    errors = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    win_pos = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = nma_pkg::RegRadius0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    window_start_i = 1'b0;
    out_ready_i = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window of nine with the extremes, then an abandoned window.
    send(16'sh7fff, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh0000, 1'b0);
    send(16'shffff, 1'b0);
    send(16'sh0001, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh0100, 1'b0);
    send(16'shff00, 1'b0);
    send(16'sh1234, 1'b1);
    send(16'sh4321, 1'b0);
    send(16'sh0777, 1'b0);
    repeat (9) send(16'sh0005, (win_pos++ == 0));
    win_pos = 0;

    set_radii(2'd0, 2'd0, 2'd0);
    send(16'sh7fff, 1'b0);
    send(16'sh8000, 1'b1);
    send(16'sh0000, 1'b0);
    run_windows(150);

    set_radii(2'd1, 2'd0, 2'd0);
    run_windows(150);
    drain();
    run_windows(50);

    set_radii(2'd3, 2'd3, 2'd3);
    run_windows(260);

    set_radii(2'd2, 2'd1, 2'd0);
    run_windows(200);

    set_radii(2'd0, 2'd2, 2'd1);
    run_windows(150);

    set_radii(2'd1, 2'd1, 2'd1);
    run_windows(170);

    in_valid_i <= 1'b0;
    while (sb.medians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
